/* rtl/mts_pkg.sv */
// shared types, codes and note tables of the melody tone sequencer
`default_nettype none

package mts_pkg;

    // request kinds carried in the input tuser
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_MODE = 2'd1;
    localparam logic [1:0] REQ_BEEP = 2'd2;

    // music modes, unused codes behave as off
    localparam logic [2:0] MODE_OFF  = 3'd0;
    localparam logic [2:0] MODE_PLAY = 3'd1;
    localparam logic [2:0] MODE_IDLE = 3'd2;
    localparam logic [2:0] MODE_WIN  = 3'd3;
    localparam logic [2:0] MODE_LOSS = 3'd4;

    // tone timer tops: 16 MHz / (2 * 256 * f) - 1
    localparam logic [7:0] TOP_C4   = 8'd118;
    localparam logic [7:0] TOP_D4   = 8'd105;
    localparam logic [7:0] TOP_E4   = 8'd93;
    localparam logic [7:0] TOP_F4   = 8'd88;
    localparam logic [7:0] TOP_G4   = 8'd78;
    localparam logic [7:0] TOP_A4   = 8'd70;
    localparam logic [7:0] TOP_B4   = 8'd62;
    localparam logic [7:0] TOP_C5   = 8'd58;
    localparam logic [7:0] TOP_D5   = 8'd52;
    localparam logic [7:0] TOP_E5   = 8'd46;
    localparam logic [7:0] TOP_F5   = 8'd43;
    localparam logic [7:0] TOP_G5   = 8'd38;
    localparam logic [7:0] TOP_C6   = 8'd28;
    localparam logic [7:0] TOP_BEEP = 8'd19;

    // which table the tone rom reads
    typedef enum logic [2:0] {
        TONE_REST = 3'd0,
        TONE_PLAY = 3'd1,
        TONE_IDLE = 3'd2,
        TONE_WIN  = 3'd3,
        TONE_LOSS = 3'd4,
        TONE_BEEP = 3'd5
    } t_tone_sel;

    // tone rom read request
    typedef struct packed {
        t_tone_sel  sel;
        logic [3:0] idx;
    } t_rom_req;

    // rom word: sound flag over timer top, a rest reads as zero
    function automatic logic [8:0] f_tone_top(input t_tone_sel sel, input logic [3:0] idx);
        logic [7:0] top;
        top = 8'd0;
        case (sel)
            TONE_PLAY: begin
                case (idx)
                    4'd0:    top = TOP_C4;
                    4'd1:    top = TOP_E4;
                    4'd2:    top = TOP_G4;
                    4'd3:    top = TOP_C5;
                    4'd4:    top = TOP_D4;
                    4'd5:    top = TOP_F4;
                    4'd6:    top = TOP_A4;
                    4'd7:    top = TOP_D5;
                    4'd8:    top = TOP_E4;
                    4'd9:    top = TOP_G4;
                    4'd10:   top = TOP_B4;
                    4'd11:   top = TOP_E5;
                    4'd12:   top = TOP_F4;
                    4'd13:   top = TOP_A4;
                    4'd14:   top = TOP_C5;
                    default: top = TOP_F5;
                endcase
            end
            TONE_IDLE: begin
                case (idx)
                    4'd0:    top = TOP_C4;
                    4'd1:    top = TOP_G4;
                    4'd2:    top = TOP_A4;
                    4'd3:    top = TOP_F4;
                    4'd4:    top = TOP_E4;
                    4'd5:    top = TOP_D4;
                    4'd6:    top = TOP_C4;
                    default: top = 8'd0;
                endcase
            end
            TONE_WIN: begin
                case (idx)
                    4'd0:    top = TOP_C5;
                    4'd1:    top = TOP_E5;
                    4'd2:    top = TOP_G5;
                    4'd3:    top = TOP_C6;
                    4'd5:    top = TOP_G5;
                    4'd6:    top = TOP_C6;
                    default: top = 8'd0;
                endcase
            end
            TONE_LOSS: begin
                case (idx)
                    4'd0:    top = TOP_G4;
                    4'd1:    top = TOP_E4;
                    4'd2:    top = TOP_C4;
                    default: top = 8'd0;
                endcase
            end
            TONE_BEEP: top = TOP_BEEP;
            default:   top = 8'd0;
        endcase
        return {(top != 8'd0), top};
    endfunction

    // win tune note lengths in ms
    function automatic logic [15:0] f_win_dur(input logic [3:0] idx);
        logic [15:0] d;
        case (idx)
            4'd3:    d = 16'd200;
            4'd4:    d = 16'd50;
            4'd6:    d = 16'd300;
            default: d = 16'd100;
        endcase
        return d;
    endfunction

    // loss tune note lengths in ms
    function automatic logic [15:0] f_loss_dur(input logic [3:0] idx);
        logic [15:0] d;
        case (idx)
            4'd0:    d = 16'd200;
            4'd1:    d = 16'd200;
            4'd2:    d = 16'd400;
            default: d = 16'd100;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

/* rtl/mts_tone_rom.sv */
// synchronous tone rom: note tables to timer top, registered read
`default_nettype none

module mts_tone_rom
    import mts_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_en,
    input  wire t_rom_req   i_req,
    output logic            o_sound,
    output logic [7:0]      o_top
);

    logic [8:0] r_word;

    // registered read, data holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= f_tone_top(i_req.sel, i_req.idx);
        end
    end

    assign o_sound = r_word[8];
    assign o_top   = r_word[7:0];

endmodule

`default_nettype wire

/* rtl/melody_tone_sequencer_unit.sv */
// melody tone sequencer: tick-driven note stepping with a tone rom read stage
//
// Input stream (s_axis): tuser carries the request kind (tick, select mode,
// start placement beep); tdata carries tick_ms, new_mode and beep_ms. Only a
// tick produces a result beat; mode and beep requests update state silently.
// Output stream (m_axis): one beat per tick with tone_enable, timer_top,
// timer_compare and note_position for the tone timer.
// Pipeline: a tick accepted at a clock edge updates the note state and clocks
// the registered tone rom read at that same edge; the rom word then moves into
// the output register, which drives the result beat. One beat is taken every
// cycle while the receiver holds tready high; the note state update is a
// combinational add and compare, and the rom read is pipelined.
// When the receiver stalls, the output register holds its beat and the rom
// stage holds one more; s_axis tready drops only once both are full.
// Reset clears the mode to off, the note timer, note index, beep counter and
// held tone values, and empties the pipeline.
`default_nettype none

module melody_tone_sequencer_unit
    import mts_pkg::*;
#(
    parameter int GAMEPLAY_NOTES   = 16,
    parameter int WIN_NOTES        = 7,
    parameter int LOSS_NOTES       = 4,
    parameter int IDLE_NOTES       = 8,
    parameter int GAMEPLAY_NOTE_MS = 150,
    parameter int IDLE_NOTE_MS     = 300
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [7:0] tick_ms, [10:8] new_mode, [18:11] beep_ms, [23:19] zero
    input  wire logic [23:0] i_s_axis_tdata,
    // [1:0] req_type
    input  wire logic [1:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [0] tone_enable, [8:1] timer_top, [15:9] timer_compare,
    // [19:16] note_position, [23:20] zero
    output logic [23:0]      o_m_axis_tdata
);

    localparam logic [4:0]  L_PLAY_LEN = 5'(GAMEPLAY_NOTES);
    localparam logic [4:0]  L_IDLE_LEN = 5'(IDLE_NOTES);
    localparam logic [4:0]  L_WIN_LEN  = 5'(WIN_NOTES);
    localparam logic [4:0]  L_LOSS_CNT = 5'(LOSS_NOTES);
    localparam logic [15:0] L_PLAY_MS  = 16'(GAMEPLAY_NOTE_MS);
    localparam logic [15:0] L_IDLE_MS  = 16'(IDLE_NOTE_MS);

    // sequencer state
    logic [2:0]  r_mode,     n_mode;
    logic [15:0] r_timer,    n_timer;
    logic [3:0]  r_note_idx, n_note_idx;
    logic [7:0]  r_beep,     n_beep;
    logic        r_finished, n_finished;

    // rom stage and output stage
    logic        r_b_valid;
    logic [3:0]  r_b_pos;
    logic        r_o_valid;
    logic        r_o_enable;
    logic [7:0]  r_o_top;
    logic [3:0]  r_o_pos;
    logic [7:0]  r_held_top;

    logic        w_s_accept;
    logic        w_tick;
    logic        w_adv_b;
    logic [1:0]  w_req;
    logic [7:0]  w_tick_ms;
    logic [2:0]  w_new_mode;
    logic [7:0]  w_beep_ms;
    logic [15:0] w_sum;
    logic [4:0]  w_inc;
    logic [15:0] w_dur;
    logic [4:0]  w_len;
    t_rom_req    w_rom_req;
    logic        w_rom_sound;
    logic [7:0]  w_rom_top;
    logic [7:0]  w_top_sel;

    assign w_req      = i_s_axis_tuser;
    assign w_tick_ms  = i_s_axis_tdata[7:0];
    assign w_new_mode = i_s_axis_tdata[10:8];
    assign w_beep_ms  = i_s_axis_tdata[18:11];

    // handshake: rom stage moves on when the output register frees up
    assign w_adv_b         = !r_o_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_b_valid || w_adv_b;
    assign w_s_accept      = i_s_axis_tvalid && o_s_axis_tready;
    assign w_tick          = w_s_accept && (w_req == REQ_TICK);

    assign w_sum = r_timer + 16'(w_tick_ms);
    assign w_inc = {1'b0, r_note_idx} + 5'd1;

    // one-shot tune lengths
    always_comb begin
        if (r_mode == MODE_WIN) begin
            w_dur = f_win_dur(r_note_idx);
            w_len = L_WIN_LEN;
        end else begin
            w_dur = f_loss_dur(r_note_idx);
            w_len = L_LOSS_CNT;
        end
    end

    // next sequencer state and rom address
    always_comb begin
        n_mode        = r_mode;
        n_timer       = r_timer;
        n_note_idx    = r_note_idx;
        n_beep        = r_beep;
        n_finished    = r_finished;
        w_rom_req.sel = TONE_REST;
        w_rom_req.idx = r_note_idx;
        if (w_s_accept) begin
            case (w_req)
                REQ_MODE: begin
                    n_mode     = w_new_mode;
                    n_timer    = 16'd0;
                    n_note_idx = 4'd0;
                    n_finished = 1'b0;
                end
                REQ_BEEP: begin
                    n_beep = w_beep_ms;
                end
                REQ_TICK: begin
                    n_timer = w_sum;
                    n_beep  = (r_beep >= w_tick_ms) ? (r_beep - w_tick_ms) : 8'd0;
                    case (r_mode)
                        MODE_PLAY: begin
                            if (w_sum >= L_PLAY_MS) begin
                                n_timer    = 16'd0;
                                n_note_idx = (w_inc >= L_PLAY_LEN) ? 4'd0 : w_inc[3:0];
                            end
                            w_rom_req.sel = (n_beep != 8'd0) ? TONE_BEEP : TONE_PLAY;
                        end
                        MODE_IDLE: begin
                            if (w_sum >= L_IDLE_MS) begin
                                n_timer    = 16'd0;
                                n_note_idx = (w_inc >= L_IDLE_LEN) ? 4'd0 : w_inc[3:0];
                            end
                            w_rom_req.sel = TONE_IDLE;
                        end
                        MODE_WIN, MODE_LOSS: begin
                            if (!r_finished) begin
                                if (w_sum >= w_dur) begin
                                    n_timer = 16'd0;
                                    if (w_inc >= w_len) begin
                                        n_finished = 1'b1;
                                    end else begin
                                        n_note_idx = w_inc[3:0];
                                    end
                                end
                                if (!n_finished) begin
                                    w_rom_req.sel = (r_mode == MODE_WIN) ? TONE_WIN : TONE_LOSS;
                                end
                            end
                        end
                        default: begin
                            w_rom_req.sel = TONE_REST;
                        end
                    endcase
                    w_rom_req.idx = n_note_idx;
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_OFF;
            r_timer    <= 16'd0;
            r_note_idx <= 4'd0;
            r_beep     <= 8'd0;
            r_finished <= 1'b0;
        end else begin
            r_mode     <= n_mode;
            r_timer    <= n_timer;
            r_note_idx <= n_note_idx;
            r_beep     <= n_beep;
            r_finished <= n_finished;
        end
    end

    // tone rom read stage
    mts_tone_rom u_rom (
        .i_clk   (i_clk),
        .i_en    (w_tick),
        .i_req   (w_rom_req),
        .o_sound (w_rom_sound),
        .o_top   (w_rom_top)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_tick) begin
            r_b_valid <= 1'b1;
        end else if (w_adv_b) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_b_pos <= n_note_idx;
        end
    end

    // rests repeat the last sounding top
    assign w_top_sel = w_rom_sound ? w_rom_top : r_held_top;

    // output register and held tone value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid  <= 1'b0;
            r_held_top <= 8'd0;
        end else if (w_adv_b) begin
            r_o_valid <= r_b_valid;
            if (r_b_valid) begin
                r_held_top <= w_top_sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_b && r_b_valid) begin
            r_o_enable <= w_rom_sound;
            r_o_top    <= w_top_sel;
            r_o_pos    <= r_b_pos;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {4'd0, r_o_pos, r_o_top[7:1], r_o_top, r_o_enable};

    // a tick always reaches the rom stage on the next cycle
    a_tick_to_rom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick |=> r_b_valid)
        else $error("tick did not enter the rom stage");

    // a finished one-shot tune keeps its index until a mode request
    a_finished_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_finished && !(w_s_accept && (w_req == REQ_MODE))) |=>
            ($stable(r_note_idx) && r_finished))
        else $error("finished tune moved its note index");

    // looping tunes keep the index inside the tune
    a_loop_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_PLAY || r_mode == MODE_IDLE) |->
            ({1'b0, r_note_idx} < ((r_mode == MODE_PLAY) ? L_PLAY_LEN : L_IDLE_LEN)))
        else $error("note index past the end of a looping tune");

    // output beat always carries the held top
    a_held_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_top == r_held_top))
        else $error("output top differs from the held top");

endmodule

`default_nettype wire
